FILE: hdl/icmp_erm_pkg.sv
// ----------------------------------------------------------------------------
// icmp_erm_pkg
// Shared types, header offsets and constants for the ICMP echo reply matcher.
// ----------------------------------------------------------------------------
package icmp_erm_pkg;

  // default frame byte counter width
  localparam int COUNT_BITS_DEF = 16;

  // configuration port
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_SRC_ADDR = 2'd0,
    REG_DST_ADDR = 2'd1,
    REG_IDENT    = 2'd2,
    REG_SEQUENCE = 2'd3
  } reg_idx_t;

  // header sizes in bytes
  localparam int ETH_HDR    = 14;
  localparam int IP_MIN_HDR = 20;
  localparam int ECHO_HDR   = 8;

  // byte offsets inside the frame
  localparam int OFS_TYPE_HI  = 12;
  localparam int OFS_TYPE_LO  = 13;
  localparam int OFS_VER_IHL  = 14;
  localparam int OFS_LEN_HI   = 16;
  localparam int OFS_LEN_LO   = 17;
  localparam int OFS_PROTO    = 23;
  localparam int OFS_SRC_FIRST = 26;
  localparam int OFS_SRC_LAST  = 29;
  localparam int OFS_DST_FIRST = 30;
  localparam int OFS_DST_LAST  = 33;

  // offsets inside the echo header
  localparam int ECHO_KIND   = 0;
  localparam int ECHO_CODE   = 1;
  localparam int ECHO_ID_HI  = 4;
  localparam int ECHO_ID_LO  = 5;
  localparam int ECHO_SEQ_HI = 6;
  localparam int ECHO_SEQ_LO = 7;

  // expected header values
  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4    = 4'd4;
  localparam logic [3:0]  IHL_MIN         = 4'd5;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
  localparam logic [7:0]  ICMP_CODE_ZERO  = 8'd0;

  // configured match values
  typedef struct packed {
    logic [31:0] want_src_addr;
    logic [31:0] want_dst_addr;
    logic [15:0] want_ident;
    logic [15:0] want_sequence;
  } cfg_t;

  // header fields captured from the frame
  typedef struct packed {
    logic [15:0] ether_kind;
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic [15:0] ip_length;
    logic [7:0]  ip_protocol;
    logic [31:0] seen_src;
    logic [31:0] seen_dst;
    logic [7:0]  msg_kind;
    logic [7:0]  msg_code;
    logic [15:0] seen_ident;
    logic [15:0] seen_sequence;
  } hdr_t;

endpackage

FILE: hdl/icmp_erm_regs.sv
// ----------------------------------------------------------------------------
// icmp_erm_regs
// APB register bank holding the expected addresses, identifier and sequence.
// ----------------------------------------------------------------------------
module icmp_erm_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [icmp_erm_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [icmp_erm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [icmp_erm_pkg::DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output icmp_erm_pkg::cfg_t                  cfg
);

  icmp_erm_pkg::reg_idx_t idx;
  logic                   wr_en;

  assign idx    = icmp_erm_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        icmp_erm_pkg::REG_SRC_ADDR: cfg.want_src_addr <= pwdata;
        icmp_erm_pkg::REG_DST_ADDR: cfg.want_dst_addr <= pwdata;
        icmp_erm_pkg::REG_IDENT:    cfg.want_ident    <= pwdata[15:0];
        icmp_erm_pkg::REG_SEQUENCE: cfg.want_sequence <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      icmp_erm_pkg::REG_SRC_ADDR: prdata = cfg.want_src_addr;
      icmp_erm_pkg::REG_DST_ADDR: prdata = cfg.want_dst_addr;
      icmp_erm_pkg::REG_IDENT:    prdata = {16'd0, cfg.want_ident};
      icmp_erm_pkg::REG_SEQUENCE: prdata = {16'd0, cfg.want_sequence};
      default:                    prdata = '0;
    endcase
  end

endmodule

FILE: hdl/icmp_erm_parser.sv
// ----------------------------------------------------------------------------
// icmp_erm_parser
// Byte counter and header capture; presents the fields including this byte.
// ----------------------------------------------------------------------------
module icmp_erm_parser #(
  parameter int COUNT_BITS = icmp_erm_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [7:0]             byte_in,
  input  logic                   last_in,
  output icmp_erm_pkg::hdr_t     hdr_next,
  output logic [COUNT_BITS-1:0]  byte_count
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] byte_index;
  icmp_erm_pkg::hdr_t    hdr;
  logic [6:0]            base;
  logic [COUNT_BITS-1:0] pos_rel;

  // length including this byte, saturating
  assign byte_count = (byte_index == COUNT_MAX) ? COUNT_MAX : byte_index + 1'b1;

  // start of the echo header from the captured IHL
  assign base    = 7'(icmp_erm_pkg::ETH_HDR) + {1'b0, hdr.header_words, 2'b00};
  assign pos_rel = byte_index - COUNT_BITS'(base);

  // field capture at fixed and IHL-relative offsets
  always_comb begin
    hdr_next = hdr;
    if (byte_index inside {icmp_erm_pkg::OFS_TYPE_HI, icmp_erm_pkg::OFS_TYPE_LO}) begin
      hdr_next.ether_kind = {hdr.ether_kind[7:0], byte_in};
    end else if (byte_index == COUNT_BITS'(icmp_erm_pkg::OFS_VER_IHL)) begin
      hdr_next.ip_version   = byte_in[7:4];
      hdr_next.header_words = byte_in[3:0];
    end else if (byte_index inside {icmp_erm_pkg::OFS_LEN_HI, icmp_erm_pkg::OFS_LEN_LO}) begin
      hdr_next.ip_length = {hdr.ip_length[7:0], byte_in};
    end else if (byte_index == COUNT_BITS'(icmp_erm_pkg::OFS_PROTO)) begin
      hdr_next.ip_protocol = byte_in;
    end else if (byte_index inside
                 {[icmp_erm_pkg::OFS_SRC_FIRST:icmp_erm_pkg::OFS_SRC_LAST]}) begin
      hdr_next.seen_src = {hdr.seen_src[23:0], byte_in};
    end else if (byte_index inside
                 {[icmp_erm_pkg::OFS_DST_FIRST:icmp_erm_pkg::OFS_DST_LAST]}) begin
      hdr_next.seen_dst = {hdr.seen_dst[23:0], byte_in};
    end

    // echo header fields only once IHL is known
    if (byte_index > COUNT_BITS'(icmp_erm_pkg::ETH_HDR) &&
        byte_index >= COUNT_BITS'(base)) begin
      if (pos_rel == COUNT_BITS'(icmp_erm_pkg::ECHO_KIND)) begin
        hdr_next.msg_kind = byte_in;
      end else if (pos_rel == COUNT_BITS'(icmp_erm_pkg::ECHO_CODE)) begin
        hdr_next.msg_code = byte_in;
      end else if (pos_rel == COUNT_BITS'(icmp_erm_pkg::ECHO_ID_HI) ||
                   pos_rel == COUNT_BITS'(icmp_erm_pkg::ECHO_ID_LO)) begin
        hdr_next.seen_ident = {hdr.seen_ident[7:0], byte_in};
      end else if (pos_rel == COUNT_BITS'(icmp_erm_pkg::ECHO_SEQ_HI) ||
                   pos_rel == COUNT_BITS'(icmp_erm_pkg::ECHO_SEQ_LO)) begin
        hdr_next.seen_sequence = {hdr.seen_sequence[7:0], byte_in};
      end
    end
  end

  // frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      hdr        <= '0;
    end else if (advance) begin
      if (last_in) begin
        byte_index <= '0;
        hdr        <= '0;
      end else begin
        byte_index <= byte_count;
        hdr        <= hdr_next;
      end
    end
  end

endmodule

FILE: hdl/icmp_erm_judge.sv
// ----------------------------------------------------------------------------
// icmp_erm_judge
// Checks the captured header against constants, lengths and configuration.
// ----------------------------------------------------------------------------
module icmp_erm_judge #(
  parameter int COUNT_BITS = icmp_erm_pkg::COUNT_BITS_DEF
) (
  input  icmp_erm_pkg::hdr_t     hdr,
  input  icmp_erm_pkg::cfg_t     cfg,
  input  logic [COUNT_BITS-1:0]  byte_count,
  output logic                   match
);

  logic [5:0]  hlen;
  logic [6:0]  need_frame;
  logic [6:0]  need_ip;
  logic [16:0] ip_plus_eth;
  logic        len_ok;
  logic        hdr_ok;
  logic        id_ok;

  assign hlen        = {hdr.header_words, 2'b00};
  assign need_frame  = 7'(icmp_erm_pkg::ETH_HDR + icmp_erm_pkg::ECHO_HDR) + {1'b0, hlen};
  assign need_ip     = 7'(icmp_erm_pkg::ECHO_HDR) + {1'b0, hlen};
  assign ip_plus_eth = {1'b0, hdr.ip_length} + 17'(icmp_erm_pkg::ETH_HDR);

  // length bounds
  assign len_ok = (byte_count >= COUNT_BITS'(icmp_erm_pkg::ETH_HDR + icmp_erm_pkg::IP_MIN_HDR
                                             + icmp_erm_pkg::ECHO_HDR))
               && (byte_count >= COUNT_BITS'(need_frame))
               && (hdr.ip_length >= 16'(need_ip))
               && (ip_plus_eth <= 17'(byte_count));

  // protocol constants
  assign hdr_ok = (hdr.ether_kind == icmp_erm_pkg::ETHERTYPE_IPV4)
               && (hdr.ip_version == icmp_erm_pkg::IP_VERSION_4)
               && (hdr.header_words >= icmp_erm_pkg::IHL_MIN)
               && (hdr.ip_protocol == icmp_erm_pkg::PROTO_ICMP)
               && (hdr.msg_kind == icmp_erm_pkg::ICMP_ECHO_REPLY)
               && (hdr.msg_code == icmp_erm_pkg::ICMP_CODE_ZERO);

  // configured addresses, identifier and sequence
  assign id_ok = (hdr.seen_src == cfg.want_src_addr)
              && (hdr.seen_dst == cfg.want_dst_addr)
              && (hdr.seen_ident == cfg.want_ident)
              && (hdr.seen_sequence == cfg.want_sequence);

  assign match = len_ok && hdr_ok && id_ok;

endmodule

FILE: hdl/icmp_echo_reply_matcher_top.sv
// ----------------------------------------------------------------------------
// icmp_echo_reply_matcher_top
// Streams an Ethernet frame a byte at a time and flags an expected echo reply.
// ----------------------------------------------------------------------------
//   channel   handshake                  payload
//   rx        in_valid / in_ready        rx_byte, end_of_frame
//   result    out_valid / out_ready      is_match (one per frame, on last byte)
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One byte is accepted every cycle while in_ready is high; the last byte of a
// frame passes the input register, then its result is held in the result register.
// Header capture and all compares sit between those two registers.
// in_ready drops only while a last byte waits on a result not yet taken.
// rst is synchronous and clears the frame state, the valid flags and the configuration registers.
// ----------------------------------------------------------------------------
module icmp_echo_reply_matcher_top #(
  parameter int COUNT_BITS = icmp_erm_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [icmp_erm_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [icmp_erm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [icmp_erm_pkg::DATA_BITS-1:0]  prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          rx_byte,
  input  logic                                end_of_frame,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                is_match
);

  icmp_erm_pkg::cfg_t    cfg;
  icmp_erm_pkg::hdr_t    hdr_next;
  logic [COUNT_BITS-1:0] byte_count;
  logic                  in_q_valid;
  logic [7:0]            in_q_byte;
  logic                  in_q_eof;
  logic                  adv;
  logic                  match;

  // configuration registers
  icmp_erm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input stage moves on unless a last byte meets a full result register that is not being taken
  assign adv      = in_q_valid && (!in_q_eof || !out_valid || out_ready);
  assign in_ready = !in_q_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (adv) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= rx_byte;
      in_q_eof  <= end_of_frame;
    end
  end

  // header capture and byte count
  icmp_erm_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .advance    (adv),
    .byte_in    (in_q_byte),
    .last_in    (in_q_eof),
    .hdr_next   (hdr_next),
    .byte_count (byte_count)
  );

  // match decision
  icmp_erm_judge #(
    .COUNT_BITS (COUNT_BITS)
  ) u_judge (
    .hdr        (hdr_next),
    .cfg        (cfg),
    .byte_count (byte_count),
    .match      (match)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && in_q_eof) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_q_eof) begin
      is_match <= match;
    end
  end

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(adv && in_q_eof))
    else $error("result register overwritten");

  // backpressure only from a last byte held in the input stage
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_q_valid && in_q_eof))
    else $error("input stalled without a pending last byte");

  // every finished frame yields a result
  assert property (@(posedge clk) disable iff (rst)
    (adv && in_q_eof) |=> out_valid)
    else $error("frame end produced no result");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ICMP echo reply matcher. Frames are streamed a
// byte per transaction; a local model of the capture and compare logic works
// out the match flag of each frame, and every result is checked in order.
// Header fields, length bounds, register values, random frames and noise
// are covered under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_BITS  = icmp_erm_pkg::COUNT_BITS_DEF;
  localparam int COUNT_MAX = (1 << CNT_BITS) - 1;

  // dut ports
  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [icmp_erm_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [icmp_erm_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [icmp_erm_pkg::DATA_BITS-1:0] prdata;
  logic                               pready;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [7:0]                         rx_byte = '0;
  logic                               end_of_frame = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic                               is_match;

  // idle percentages of the two sides
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // local copy of the registers and of the frame state
  icmp_erm_pkg::cfg_t targets = '0;
  icmp_erm_pkg::hdr_t seen = '0;
  int                 frame_pos = 0;

  // match flags still to come out of the block, oldest first
  bit   pending_verdicts[$];
  int   fail_count = 0;

  // frame under construction
  logic [7:0] frame_bytes[$];

  icmp_echo_reply_matcher_top #(
    .COUNT_BITS(CNT_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .end_of_frame(end_of_frame),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_match    (is_match)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // verdict of a finished frame of len bytes
  function automatic bit reply_verdict(int len);
    int hlen;
    hlen = 4 * int'(seen.header_words);
    if (len < icmp_erm_pkg::ETH_HDR + icmp_erm_pkg::IP_MIN_HDR + icmp_erm_pkg::ECHO_HDR)
      return 1'b0;
    if (seen.ether_kind != icmp_erm_pkg::ETHERTYPE_IPV4) return 1'b0;
    if (seen.ip_version != icmp_erm_pkg::IP_VERSION_4 ||
        seen.header_words < icmp_erm_pkg::IHL_MIN) return 1'b0;
    if (len < icmp_erm_pkg::ETH_HDR + hlen + icmp_erm_pkg::ECHO_HDR) return 1'b0;
    if (seen.ip_protocol != icmp_erm_pkg::PROTO_ICMP) return 1'b0;
    if (int'(seen.ip_length) < hlen + icmp_erm_pkg::ECHO_HDR) return 1'b0;
    if (int'(seen.ip_length) > len - icmp_erm_pkg::ETH_HDR) return 1'b0;
    if (seen.seen_src != targets.want_src_addr) return 1'b0;
    if (seen.seen_dst != targets.want_dst_addr) return 1'b0;
    if (seen.msg_kind != icmp_erm_pkg::ICMP_ECHO_REPLY ||
        seen.msg_code != icmp_erm_pkg::ICMP_CODE_ZERO) return 1'b0;
    if (seen.seen_ident != targets.want_ident) return 1'b0;
    if (seen.seen_sequence != targets.want_sequence) return 1'b0;
    return 1'b1;
  endfunction

  // track one accepted byte; the last byte of a frame yields a verdict
  function automatic void absorb_byte(logic [7:0] b, logic last);
    int pos;
    int base;
    int len;
    pos = frame_pos;
    if (pos == icmp_erm_pkg::OFS_TYPE_HI || pos == icmp_erm_pkg::OFS_TYPE_LO)
      seen.ether_kind = {seen.ether_kind[7:0], b};
    else if (pos == icmp_erm_pkg::OFS_VER_IHL) begin
      seen.ip_version   = b[7:4];
      seen.header_words = b[3:0];
    end else if (pos == icmp_erm_pkg::OFS_LEN_HI || pos == icmp_erm_pkg::OFS_LEN_LO)
      seen.ip_length = {seen.ip_length[7:0], b};
    else if (pos == icmp_erm_pkg::OFS_PROTO)
      seen.ip_protocol = b;
    else if (pos >= icmp_erm_pkg::OFS_SRC_FIRST && pos <= icmp_erm_pkg::OFS_SRC_LAST)
      seen.seen_src = {seen.seen_src[23:0], b};
    else if (pos >= icmp_erm_pkg::OFS_DST_FIRST && pos <= icmp_erm_pkg::OFS_DST_LAST)
      seen.seen_dst = {seen.seen_dst[23:0], b};

    // echo header sits after the ip header, known once ihl is in
    if (pos > icmp_erm_pkg::ETH_HDR) begin
      base = icmp_erm_pkg::ETH_HDR + 4 * int'(seen.header_words);
      if (pos == base + icmp_erm_pkg::ECHO_KIND)
        seen.msg_kind = b;
      else if (pos == base + icmp_erm_pkg::ECHO_CODE)
        seen.msg_code = b;
      else if (pos == base + icmp_erm_pkg::ECHO_ID_HI ||
               pos == base + icmp_erm_pkg::ECHO_ID_LO)
        seen.seen_ident = {seen.seen_ident[7:0], b};
      else if (pos == base + icmp_erm_pkg::ECHO_SEQ_HI ||
               pos == base + icmp_erm_pkg::ECHO_SEQ_LO)
        seen.seen_sequence = {seen.seen_sequence[7:0], b};
    end

    // byte count saturates
    len = (pos < COUNT_MAX) ? pos + 1 : COUNT_MAX;
    if (!last) begin
      frame_pos = len;
    end else begin
      pending_verdicts.push_back(reply_verdict(len));
      seen      = '0;
      frame_pos = 0;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got is_match=%0b",
                 $time, is_match);
        fail_count++;
      end else if (is_match !== pending_verdicts[0]) begin
        $display("%0t ns: is_match mismatch, expected %0b, got %0b",
                 $time, pending_verdicts[0], is_match);
        fail_count++;
        void'(pending_verdicts.pop_front());
      end else begin
        void'(pending_verdicts.pop_front());
      end
    end
  end

  // send one byte transaction and wait for it to be taken
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    rx_byte      <= b;
    end_of_frame <= last;
    do @(posedge clk); while (!in_ready);
    absorb_byte(b, last);
  endtask

  // stream the frame buffer, last byte marked
  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // hold off until every result is in and the pipeline is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle
  task automatic reg_write(input icmp_erm_pkg::reg_idx_t idx,
                           input logic [icmp_erm_pkg::DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= icmp_erm_pkg::ADDR_BITS'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // load all four match registers; upper bits of the narrow ones are junk
  task automatic set_targets(input icmp_erm_pkg::cfg_t cfg);
    reg_write(icmp_erm_pkg::REG_SRC_ADDR, cfg.want_src_addr);
    reg_write(icmp_erm_pkg::REG_DST_ADDR, cfg.want_dst_addr);
    reg_write(icmp_erm_pkg::REG_IDENT, {16'($urandom), cfg.want_ident});
    reg_write(icmp_erm_pkg::REG_SEQUENCE, {16'($urandom), cfg.want_sequence});
    targets = cfg;
  endtask

  function automatic icmp_erm_pkg::cfg_t random_targets();
    icmp_erm_pkg::cfg_t cfg;
    cfg.want_src_addr = ($urandom_range(3) == 0) ? '1 : $urandom;
    cfg.want_dst_addr = ($urandom_range(3) == 0) ? '0 : $urandom;
    cfg.want_ident    = ($urandom_range(3) == 0) ? '1 : 16'($urandom);
    cfg.want_sequence = ($urandom_range(3) == 0) ? '0 : 16'($urandom);
    return cfg;
  endfunction

  function automatic void put_byte(int idx, logic [7:0] v);
    if (idx < frame_bytes.size()) frame_bytes[idx] = v;
  endfunction

  // echo reply aimed at the current targets, random filler elsewhere
  task automatic build_reply(input int ihl, input int total, input int ip_len);
    int icmp;
    icmp = icmp_erm_pkg::ETH_HDR + 4 * ihl;
    frame_bytes.delete();
    for (int i = 0; i < total; i++) frame_bytes.push_back(8'($urandom));
    put_byte(icmp_erm_pkg::OFS_TYPE_HI, icmp_erm_pkg::ETHERTYPE_IPV4[15:8]);
    put_byte(icmp_erm_pkg::OFS_TYPE_LO, icmp_erm_pkg::ETHERTYPE_IPV4[7:0]);
    put_byte(icmp_erm_pkg::OFS_VER_IHL, {icmp_erm_pkg::IP_VERSION_4, 4'(ihl)});
    put_byte(icmp_erm_pkg::OFS_LEN_HI, 8'(ip_len >> 8));
    put_byte(icmp_erm_pkg::OFS_LEN_LO, 8'(ip_len));
    put_byte(icmp_erm_pkg::OFS_PROTO, icmp_erm_pkg::PROTO_ICMP);
    for (int k = 0; k < 4; k++) begin
      put_byte(icmp_erm_pkg::OFS_SRC_FIRST + k, targets.want_src_addr[31 - 8 * k -: 8]);
      put_byte(icmp_erm_pkg::OFS_DST_FIRST + k, targets.want_dst_addr[31 - 8 * k -: 8]);
    end
    put_byte(icmp + icmp_erm_pkg::ECHO_KIND, icmp_erm_pkg::ICMP_ECHO_REPLY);
    put_byte(icmp + icmp_erm_pkg::ECHO_CODE, icmp_erm_pkg::ICMP_CODE_ZERO);
    put_byte(icmp + icmp_erm_pkg::ECHO_ID_HI, targets.want_ident[15:8]);
    put_byte(icmp + icmp_erm_pkg::ECHO_ID_LO, targets.want_ident[7:0]);
    put_byte(icmp + icmp_erm_pkg::ECHO_SEQ_HI, targets.want_sequence[15:8]);
    put_byte(icmp + icmp_erm_pkg::ECHO_SEQ_LO, targets.want_sequence[7:0]);
  endtask

  // registers at their reset value, plus a one-byte frame
  task automatic test_reset_defaults();
    build_reply(5, 50, 36);
    send_frame();
    frame_bytes.delete();
    frame_bytes.push_back(8'h45);
    send_frame();
  endtask

  // each header field wrong in turn
  task automatic test_header_checks();
    int icmp;
    icmp = icmp_erm_pkg::ETH_HDR + 4 * icmp_erm_pkg::IHL_MIN;
    drain_results();
    set_targets(random_targets());
    for (int c = 0; c < 12; c++) begin
      build_reply(icmp_erm_pkg::IHL_MIN, 46, 32);
      case (c)
        1:  put_byte(icmp_erm_pkg::OFS_TYPE_HI, 8'h86);
        2:  put_byte(icmp_erm_pkg::OFS_VER_IHL, 8'h65);
        3:  put_byte(icmp_erm_pkg::OFS_VER_IHL, 8'h44);
        4:  put_byte(icmp_erm_pkg::OFS_VER_IHL, 8'h40);
        5:  put_byte(icmp_erm_pkg::OFS_PROTO, 8'd6);
        6:  put_byte(icmp + icmp_erm_pkg::ECHO_KIND, 8'd8);
        7:  put_byte(icmp + icmp_erm_pkg::ECHO_CODE, 8'hff);
        8:  put_byte(icmp_erm_pkg::OFS_SRC_LAST, ~frame_bytes[icmp_erm_pkg::OFS_SRC_LAST]);
        9:  put_byte(icmp_erm_pkg::OFS_DST_FIRST, ~frame_bytes[icmp_erm_pkg::OFS_DST_FIRST]);
        10: put_byte(icmp + icmp_erm_pkg::ECHO_ID_LO,
                     ~frame_bytes[icmp + icmp_erm_pkg::ECHO_ID_LO]);
        11: put_byte(icmp + icmp_erm_pkg::ECHO_SEQ_HI,
                     ~frame_bytes[icmp + icmp_erm_pkg::ECHO_SEQ_HI]);
        default: ;
      endcase
      send_frame();
    end
  endtask

  // frame and total length bounds
  task automatic test_length_checks();
    build_reply(5, 42, 28);     // smallest reply, ip length exactly fits
    send_frame();
    build_reply(5, 41, 27);     // one byte short
    send_frame();
    build_reply(5, 50, 27);     // ip length below header plus echo
    send_frame();
    build_reply(5, 50, 37);     // ip length past the frame end
    send_frame();
    build_reply(5, 60, 30);     // trailing padding after the datagram
    send_frame();
    build_reply(15, 82, 68);    // largest ip header
    send_frame();
    build_reply(6, 45, 31);     // options push the echo header off the end
    send_frame();
  endtask

  // all-ones and all-zeros registers with matching frames
  task automatic test_register_extremes();
    icmp_erm_pkg::cfg_t cfg;
    drain_results();
    cfg = '1;
    set_targets(cfg);
    build_reply(5, 48, 34);
    for (int i = 42; i < 48; i++) frame_bytes[i] = 8'hff;
    send_frame();
    drain_results();
    cfg = '0;
    set_targets(cfg);
    build_reply(5, 48, 34);
    for (int i = 42; i < 48; i++) frame_bytes[i] = 8'h00;
    send_frame();
  endtask

  // random replies, damaged replies, truncated frames and noise
  task automatic test_random(input int send_pct, input int recv_pct,
                             input int min_bytes, input int min_frames);
    int sent;
    int frames;
    int kind;
    int ihl;
    int total;
    int ip_len;
    int icmp;
    sent   = 0;
    frames = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    drain_results();
    set_targets(random_targets());
    while (sent < min_bytes || frames < min_frames) begin
      // sometimes let the block run dry, sometimes retarget it
      if ($urandom_range(11) == 0) begin
        drain_results();
        if ($urandom_range(1) == 1) set_targets(random_targets());
      end
      kind   = $urandom_range(99);
      ihl    = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
      total  = icmp_erm_pkg::ETH_HDR + 4 * ihl + icmp_erm_pkg::ECHO_HDR + $urandom_range(24);
      ip_len = total - icmp_erm_pkg::ETH_HDR;
      icmp   = icmp_erm_pkg::ETH_HDR + 4 * ihl;
      case ($urandom_range(15))
        0, 1: ip_len = $urandom_range(4 * ihl + icmp_erm_pkg::ECHO_HDR,
                                      total - icmp_erm_pkg::ETH_HDR);
        2:    ip_len = total - icmp_erm_pkg::ETH_HDR + $urandom_range(1, 8);
        3:    ip_len = $urandom_range(4 * ihl + icmp_erm_pkg::ECHO_HDR - 1);
        default: ;
      endcase
      if (kind < 15) begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 80)) frame_bytes.push_back(8'($urandom));
      end else begin
        build_reply(ihl, total, ip_len);
        if (kind < 30) begin
          frame_bytes = frame_bytes[0:$urandom_range(frame_bytes.size() - 2)];
        end else if (kind < 60) begin
          case ($urandom_range(9))
            0: put_byte($urandom_range(icmp_erm_pkg::OFS_TYPE_HI, icmp_erm_pkg::OFS_TYPE_LO),
                        8'($urandom));
            1: put_byte(icmp_erm_pkg::OFS_VER_IHL, 8'($urandom));
            2: put_byte(icmp_erm_pkg::OFS_PROTO, 8'($urandom));
            3: put_byte($urandom_range(icmp_erm_pkg::OFS_SRC_FIRST,
                                       icmp_erm_pkg::OFS_SRC_LAST), 8'($urandom));
            4: put_byte($urandom_range(icmp_erm_pkg::OFS_DST_FIRST,
                                       icmp_erm_pkg::OFS_DST_LAST), 8'($urandom));
            5: put_byte(icmp + icmp_erm_pkg::ECHO_KIND,
                        ($urandom_range(1) == 1) ? 8'd8 : 8'($urandom));
            6: put_byte(icmp + icmp_erm_pkg::ECHO_CODE, 8'($urandom));
            7: put_byte(icmp + $urandom_range(icmp_erm_pkg::ECHO_ID_HI,
                                              icmp_erm_pkg::ECHO_ID_LO), 8'($urandom));
            8: put_byte(icmp + $urandom_range(icmp_erm_pkg::ECHO_SEQ_HI,
                                              icmp_erm_pkg::ECHO_SEQ_LO), 8'($urandom));
            default: put_byte($urandom_range(total - 1), 8'($urandom));
          endcase
        end
      end
      send_frame();
      sent += frame_bytes.size();
      frames++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 30;
    recv_idle_pct = 49;
    test_reset_defaults();
    test_header_checks();
    test_length_checks();
    test_register_extremes();
    test_random(30, 49, 100, 2);
    test_random(49, 30, 100, 2);
    test_random(0, 0, 100, 2);
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
